[sv/kepler_eccentric_anomaly_series_defines.svh]
// Assertion macros for the Kepler series port checker.
`ifndef KEPLER_ECCENTRIC_ANOMALY_SERIES_DEFINES_SVH
`define KEPLER_ECCENTRIC_ANOMALY_SERIES_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define KEPEA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kepea port check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define KEPEA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kepea port check failed");

`endif

[sv/kepea_pkg.sv]
// Types, constants and fixed-point helpers for the Kepler series block.
`default_nettype none

package kepea_pkg;

    localparam int ANGLE_BITS = 32;
    localparam int ECC_BITS   = 16;
    localparam int TAG_BITS   = 16;
    localparam int RES_BITS   = 32;
    localparam int TERMS      = 6;

    // 2*pi in Q3.28 scaled for a Q0.32 turn
    localparam logic [30:0] RAD_SCALE = 31'd1686629713;
    localparam logic [30:0] Q30_ONE   = 31'h4000_0000;

    // Taylor denominators of the sine, innermost first
    localparam int HORNER_DEN [TERMS] = '{156, 110, 72, 42, 20, 6};

    // Reciprocal multipliers: q = (a * MUL) >> SHIFT, exact for the input width
    localparam int          DIV3_SHIFT  = 34;
    localparam logic [32:0] DIV3_MUL    = 33'(((65'd1 << DIV3_SHIFT) + 65'd2) / 65'd3);
    localparam int          DIV5_SHIFT  = 36;
    localparam logic [33:0] DIV5_MUL    = 34'(((65'd1 << DIV5_SHIFT) + 65'd4) / 65'd5);
    localparam int          DIV15_SHIFT = 38;
    localparam logic [34:0] DIV15_MUL   = 35'(((65'd1 << DIV15_SHIFT) + 65'd14) / 65'd15);

    typedef struct packed {
        logic [TAG_BITS-1:0]   body_tag;
        logic [ECC_BITS-1:0]   eccentricity;
        logic [ANGLE_BITS-1:0] mean_anomaly;
    } kepea_req_t;

    typedef struct packed {
        logic [TAG_BITS-1:0]        tag_out;
        logic signed [RES_BITS-1:0] eccentric_anomaly;
    } kepea_rsp_t;

    function automatic logic [31:0] qmul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] prod;
        prod = 64'(a) * 64'(b);
        return prod[63:32];
    endfunction

    function automatic logic [31:0] div3(input logic [31:0] a);
        logic [64:0] prod;
        prod = 65'(a) * 65'(DIV3_MUL);
        return 32'(prod >> DIV3_SHIFT);
    endfunction

    function automatic logic [31:0] div5(input logic [32:0] a);
        logic [66:0] prod;
        prod = 67'(a) * 67'(DIV5_MUL);
        return 32'(prod >> DIV5_SHIFT);
    endfunction

    function automatic logic [31:0] div15(input logic [33:0] a);
        logic [68:0] prod;
        prod = 69'(a) * 69'(DIV15_MUL);
        return 32'(prod >> DIV15_SHIFT);
    endfunction

endpackage

`default_nettype wire

[sv/kepea_sin_lane.sv]
// Pipelined sine of a 32-bit turn fraction: quadrant fold, Horner Taylor series.
`default_nettype none

module kepea_sin_lane
    import kepea_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] turn,
    output logic [30:0] sin_mag,
    output logic        sin_neg
);

    localparam int XDEPTH  = 2 * TERMS + 2;
    localparam int X2DEPTH = 2 * TERMS - 1;
    localparam int SDEPTH  = 2 * TERMS + 3;

    logic [32:0] r_base;
    logic [32:0] r_fold;
    logic [30:0] x_next;

    logic [30:0]        x_reg  [XDEPTH];
    logic [31:0]        x2_reg [X2DEPTH];
    logic [31:0]        p_reg  [TERMS];
    logic [30:0]        t_reg  [TERMS];
    logic [SDEPTH-1:0]  neg_reg;
    logic [30:0]        s_reg;

    assign r_base = {1'b0, turn[29:0], 2'b00};
    // odd quadrants mirror the angle about pi/2
    assign r_fold = turn[30] ? (33'h1_0000_0000 - r_base) : r_base;
    assign x_next = 31'((64'(r_fold) * 64'(RAD_SCALE)) >> 32);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= x_next;
            neg_reg[0] <= turn[31];
            for (int j = 1; j < XDEPTH; j++)
            begin
                x_reg[j] <= x_reg[j-1];
            end
            for (int j = 1; j < SDEPTH; j++)
            begin
                neg_reg[j] <= neg_reg[j-1];
            end
            x2_reg[0] <= 32'((62'(x_reg[0]) * 62'(x_reg[0])) >> 30);
            for (int j = 1; j < X2DEPTH; j++)
            begin
                x2_reg[j] <= x2_reg[j-1];
            end
            s_reg <= 31'((62'(x_reg[XDEPTH-1]) * 62'(t_reg[TERMS-1])) >> 30);
        end
    end

    for (genvar i = 0; i < TERMS; i++)
    begin : g_step
        localparam int          SH  = 32 + $clog2(HORNER_DEN[i]);
        localparam logic [32:0] MUL = 33'(((65'd1 << SH) + 65'(HORNER_DEN[i]) - 65'd1)
                                          / 65'(HORNER_DEN[i]));
        logic [30:0] t_in;
        logic [31:0] d;

        if (i == 0)
        begin : g_first
            assign t_in = Q30_ONE;
        end
        else
        begin : g_next
            assign t_in = t_reg[i-1];
        end

        assign d = 32'((65'(p_reg[i]) * 65'(MUL)) >> SH);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[i] <= 32'((63'(x2_reg[2*i]) * 63'(t_in)) >> 30);
                t_reg[i] <= (d > 32'(Q30_ONE)) ? 31'd0 : 31'(32'(Q30_ONE) - d);
            end
        end
    end

    assign sin_mag = s_reg;
    assign sin_neg = neg_reg[SDEPTH-1];

endmodule

`default_nettype wire

[sv/kepler_eccentric_anomaly_series.sv]
// Kepler eccentric anomaly by the sixth-order series in e, fully pipelined.
// Request channel req_valid/req_ready/req_data carries body tag, eccentricity
// (Q0.16) and mean anomaly (32-bit turn fraction). Response channel
// rsp_valid/rsp_ready/rsp_data returns the tag and E in signed Q3.28 radians,
// saturated. One request is taken per cycle while the skid entry is empty.
// The depth is set by the sine lanes: a fold multiply, x^2, six Horner steps
// of multiply plus reciprocal divide, and a final multiply, then a split
// coefficient product and a two-level sum. The power chain e^2..e^6 and the
// coefficient divides run alongside and are delayed to meet the sines.
// Responses land in an output register backed by one skid entry; req_ready
// drops only while the skid entry is full, which freezes the whole pipeline
// until the response is taken, so nothing is lost or repeated.
// Reset (rst_n low, asynchronous) clears the valid bits, the output valid bit
// and the skid flag; payload registers and the output data are not reset.
`default_nettype none

module kepler_eccentric_anomaly_series
    import kepea_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  kepea_req_t req_data,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output kepea_rsp_t rsp_data
);

    localparam int PIPE_DEPTH = 20;
    localparam int MRAD_DEPTH = 18;
    localparam int C_DEPTH    = 8;
    localparam int NPOW       = 6;
    localparam logic signed [37:0] RES_MAX = 38'sd2147483647;
    localparam logic signed [37:0] RES_MIN = -38'sd2147483648;

    logic en;
    logic take;

    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  rsp_valid_reg;
    logic                  skid_valid_reg;
    kepea_rsp_t            rsp_reg;
    kepea_rsp_t            skid_reg;
    kepea_rsp_t            last;

    logic [TAG_BITS-1:0]   tag_reg  [PIPE_DEPTH];
    logic [31:0]           turn_reg [TERMS];
    logic [31:0]           mturn_reg;
    logic [30:0]           mrad_reg [MRAD_DEPTH];
    logic [31:0]           pow_reg  [NPOW][NPOW];

    logic [31:0]           num3_reg  [5];
    logic [33:0]           num15_reg;
    logic [32:0]           num5_reg;
    logic [31:0]           ex_reg    [5];
    logic [31:0]           q3_reg    [5];
    logic [31:0]           q15_reg;
    logic [31:0]           q5_reg;
    logic [31:0]           ex8_reg   [5];
    logic signed [34:0]    c_reg     [C_DEPTH][TERMS];

    logic [30:0]           sin_mag  [TERMS];
    logic                  sin_neg  [TERMS];
    logic signed [50:0]    pp_hi_reg [TERMS];
    logic signed [51:0]    pp_lo_reg [TERMS];
    logic                  neg17_reg [TERMS];
    logic signed [33:0]    term_reg  [TERMS];
    logic signed [35:0]    psum_reg  [3];
    logic signed [RES_BITS-1:0] res_reg;

    logic [ANGLE_BITS-1:0] km      [TERMS];
    logic [31:0]           turn_next [TERMS];
    logic [31:0]           e1_next;
    logic [31:0]           mturn_next;
    logic signed [34:0]    c_next  [TERMS];
    logic signed [37:0]    total;

    assign en        = !skid_valid_reg;
    assign req_ready = en;
    assign take      = req_valid && en;

    assign e1_next = 32'(req_data.eccentricity) << (32 - ECC_BITS);

    for (genvar k = 0; k < TERMS; k++)
    begin : g_angle
        assign km[k] = req_data.mean_anomaly * ANGLE_BITS'(k + 1);
        if (ANGLE_BITS >= 32)
        begin : g_cut
            assign turn_next[k] = 32'(km[k] >> (ANGLE_BITS - 32));
        end
        else
        begin : g_widen
            assign turn_next[k] = 32'(km[k]) << (32 - ANGLE_BITS);
        end

        kepea_sin_lane u_lane (
            .clk     (clk),
            .en      (en),
            .turn    (turn_reg[k]),
            .sin_mag (sin_mag[k]),
            .sin_neg (sin_neg[k])
        );
    end

    assign mturn_next = turn_next[0];

    // coefficient polynomials from the carried exact parts and the quotients
    always_comb
    begin
        c_next[0] = 35'(ex8_reg[0]) - 35'(ex8_reg[1]) + 35'(q3_reg[0]);
        c_next[1] = 35'(ex8_reg[2]) - 35'(q3_reg[1]) + 35'(q3_reg[2]);
        c_next[2] = 35'(ex8_reg[3]) - 35'(ex8_reg[4]);
        c_next[3] = 35'(q3_reg[3]) - 35'(q15_reg);
        c_next[4] = 35'(q3_reg[4]);
        c_next[5] = 35'(q5_reg);
    end

    assign total = 38'(psum_reg[0]) + 38'(psum_reg[1]) + 38'(psum_reg[2])
                 + 38'(mrad_reg[MRAD_DEPTH-1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: capture
            tag_reg[0] <= req_data.body_tag;
            for (int j = 1; j < PIPE_DEPTH; j++)
            begin
                tag_reg[j] <= tag_reg[j-1];
            end
            for (int k = 0; k < TERMS; k++)
            begin
                turn_reg[k] <= turn_next[k];
            end
            mturn_reg     <= mturn_next;
            pow_reg[0][0] <= e1_next;
            for (int j = 1; j < NPOW; j++)
            begin
                pow_reg[0][j] <= pow_reg[0][0];
            end

            // M in radians, delayed to the final sum
            mrad_reg[0] <= 31'((64'(mturn_reg) * 64'(RAD_SCALE)) >> 32);
            for (int j = 1; j < MRAD_DEPTH; j++)
            begin
                mrad_reg[j] <= mrad_reg[j-1];
            end

            // powers e^2..e^6, one multiply per stage
            for (int st = 1; st < NPOW; st++)
            begin
                for (int j = 0; j < NPOW; j++)
                begin
                    if (j == st)
                    begin
                        pow_reg[st][j] <= qmul32(pow_reg[st-1][st-1], pow_reg[st-1][0]);
                    end
                    else
                    begin
                        pow_reg[st][j] <= pow_reg[st-1][j];
                    end
                end
            end

            // numerators; pow_reg[5] holds e^1..e^6
            num3_reg[0] <= pow_reg[5][4] >> 6;
            num3_reg[1] <= pow_reg[5][3] >> 1;
            num3_reg[2] <= pow_reg[5][5] >> 4;
            num3_reg[3] <= pow_reg[5][3];
            num3_reg[4] <= 32'((39'(pow_reg[5][4]) * 39'd125) >> 7);
            num15_reg   <= 34'(pow_reg[5][5]) << 2;
            num5_reg    <= 33'((37'(pow_reg[5][5]) * 37'd27) >> 4);
            ex_reg[0]   <= pow_reg[5][0];
            ex_reg[1]   <= pow_reg[5][2] >> 3;
            ex_reg[2]   <= pow_reg[5][1] >> 1;
            ex_reg[3]   <= 32'((34'(pow_reg[5][2]) * 34'd3) >> 3);
            ex_reg[4]   <= 32'((37'(pow_reg[5][4]) * 37'd27) >> 7);

            // constant divides
            for (int j = 0; j < 5; j++)
            begin
                q3_reg[j]  <= div3(num3_reg[j]);
                ex8_reg[j] <= ex_reg[j];
            end
            q15_reg <= div15(num15_reg);
            q5_reg  <= div5(num5_reg);

            // coefficients, delayed to meet the sines
            for (int k = 0; k < TERMS; k++)
            begin
                c_reg[0][k] <= c_next[k];
                for (int j = 1; j < C_DEPTH; j++)
                begin
                    c_reg[j][k] <= c_reg[j-1][k];
                end
            end

            // c_k * sin((k+1)M) as two partial products, then floor to Q.28
            for (int k = 0; k < TERMS; k++)
            begin
                pp_hi_reg[k] <= c_reg[C_DEPTH-1][k] * $signed({1'b0, sin_mag[k][30:16]});
                pp_lo_reg[k] <= c_reg[C_DEPTH-1][k] * $signed({1'b0, sin_mag[k][15:0]});
                neg17_reg[k] <= sin_neg[k];
                term_reg[k]  <= 34'(((neg17_reg[k]
                                      ? -((67'(pp_hi_reg[k]) <<< 16) + 67'(pp_lo_reg[k]))
                                      :  ((67'(pp_hi_reg[k]) <<< 16) + 67'(pp_lo_reg[k]))))
                                    >>> 34);
            end

            for (int j = 0; j < 3; j++)
            begin
                psum_reg[j] <= 36'(term_reg[2*j]) + 36'(term_reg[2*j+1]);
            end

            if (total > RES_MAX)
            begin
                res_reg <= RES_MAX[RES_BITS-1:0];
            end
            else if (total < RES_MIN)
            begin
                res_reg <= RES_MIN[RES_BITS-1:0];
            end
            else
            begin
                res_reg <= total[RES_BITS-1:0];
            end
        end
    end

    assign last.tag_out           = tag_reg[PIPE_DEPTH-1];
    assign last.eccentric_anomaly = res_reg;

    // output register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[PIPE_DEPTH-2:0], take};
            end
            if (skid_valid_reg)
            begin
                if (rsp_ready)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (vld_reg[PIPE_DEPTH-1])
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (rsp_ready)
            begin
                rsp_reg <= skid_reg;
            end
        end
        else if (vld_reg[PIPE_DEPTH-1])
        begin
            if (!rsp_valid_reg || rsp_ready)
            begin
                rsp_reg <= last;
            end
            else
            begin
                skid_reg <= last;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

`default_nettype wire

[sv/kepea_sva.sv]
// Port-level checker for the Kepler series block, bound to the top level.
`default_nettype none

`include "kepler_eccentric_anomaly_series_defines.svh"

module kepea_sva
    import kepea_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_ready,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire kepea_rsp_t rsp_data
);

    `KEPEA_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
    `KEPEA_ASSERT_IMP(a_rsp_drop, $fell(rsp_valid), $past(rsp_ready))
    // pipeline freezes only when a response sat stalled
    `KEPEA_ASSERT_IMP(a_ready_fall, $fell(req_ready), $past(rsp_valid && !rsp_ready))
    // and resumes only when the held response was taken
    `KEPEA_ASSERT_IMP(a_ready_rise, $rose(req_ready), $past(rsp_valid && rsp_ready))

endmodule

bind kepler_eccentric_anomaly_series kepea_sva u_kepea_sva (.*);

`default_nettype wire

[tb/tb.sv]
// Testbench for the Kepler eccentric anomaly series block: directed and random requests.
`default_nettype none

module tb;
    import kepea_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_ready;
    kepea_req_t req_data;
    logic       rsp_valid;
    logic       rsp_ready;
    kepea_rsp_t rsp_data;

    kepea_rsp_t anomaly_q[$];
    int         err_cnt;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         hold_off_cycles;

    kepler_eccentric_anomaly_series dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data (req_data),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_data (rsp_data)
    );

    always #5 clk = ~clk;

    // signed Q.30 sine of a 32-bit turn fraction
    function automatic longint turn_sine(input logic [31:0] a);
        longint unsigned dens[6];
        longint unsigned r, x, x2, t, d;
        dens = '{156, 110, 72, 42, 20, 6};
        r = 64'(a[29:0]) << 2;
        if (a[30])
            r = (64'd1 << 32) - r;
        x = (r * 64'd1686629713) >> 32;
        x2 = (x * x) >> 30;
        t = 64'd1 << 30;
        for (int i = 0; i < 6; i++)
        begin
            d = ((x2 * t) >> 30) / dens[i];
            t = (d > (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - d;
        end
        x = (x * t) >> 30;
        return a[31] ? -longint'(x) : longint'(x);
    endfunction

    function automatic longint floor34(input longint v);
        if (v >= 0)
            return longint'(longint'(v) >>> 34);
        return -longint'((unsigned'(-v) + ((64'd1 << 34) - 1)) >> 34);
    endfunction

    function automatic kepea_rsp_t eccentric_anomaly(input kepea_req_t rq);
        longint unsigned e[7];
        longint c[6];
        longint acc;
        logic [31:0] km;
        kepea_rsp_t rs;
        e[1] = 64'(rq.eccentricity) << 16;
        for (int i = 2; i <= 6; i++)
            e[i] = (e[i-1] * e[1]) >> 32;
        c[0] = longint'(e[1]) - longint'(e[3] / 8) + longint'(e[5] / 192);
        c[1] = longint'(e[2] / 2) - longint'(e[4] / 6) + longint'(e[6] / 48);
        c[2] = longint'((e[3] * 3) / 8) - longint'((e[5] * 27) / 128);
        c[3] = longint'(e[4] / 3) - longint'((e[6] * 4) / 15);
        c[4] = longint'((e[5] * 125) / 384);
        c[5] = longint'((e[6] * 27) / 80);
        acc = longint'((64'(rq.mean_anomaly) * 64'd1686629713) >> 32);
        for (int k = 0; k < 6; k++)
        begin
            km = 32'(rq.mean_anomaly * (k + 1));
            acc += floor34(c[k] * turn_sine(km));
        end
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        rs.tag_out = rq.body_tag;
        rs.eccentric_anomaly = 32'(acc);
        return rs;
    endfunction

    task automatic send_request(input logic [15:0] tag, input logic [15:0] ecc,
                                input logic [31:0] ma);
        kepea_req_t rq;
        rq.body_tag = tag;
        rq.eccentricity = ecc;
        rq.mean_anomaly = ma;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= rq;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        anomaly_q.push_back(eccentric_anomaly(rq));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (anomaly_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed();
        logic [15:0] eccs[5];
        logic [31:0] angs[5];
        eccs = '{16'h0000, 16'h0001, 16'h8000, 16'hFFFF, 16'hF000};
        angs = '{32'h0000_0000, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000, 32'hFFFF_FFFF};
        for (int i = 0; i < 5; i++)
            for (int j = 0; j < 5; j++)
                send_request(16'(i * 5 + j) ^ ((i == 4) ? 16'hFFFF : 16'h0), eccs[i], angs[j]);
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            logic [15:0] ecc;
            ecc = ($urandom_range(3) == 0) ? 16'($urandom_range(65535, 60000))
                                           : 16'($urandom);
            send_request(16'($urandom), ecc, $urandom);
        end
    endtask

    // long receiver hold-off while requests keep coming, so the pipe backs up
    task automatic test_backpressure();
        hold_off_cycles = 200;
        test_random(60);
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        kepea_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (anomaly_q.size() == 0)
            begin
                $display("%0t: response with nothing expected: %h", $time, rsp_data);
                err_cnt++;
            end
            else
            begin
                want = anomaly_q.pop_front();
                if (rsp_data.tag_out !== want.tag_out)
                begin
                    $display("%0t: tag_out expected %h actual %h",
                             $time, want.tag_out, rsp_data.tag_out);
                    err_cnt++;
                end
                if (rsp_data.eccentric_anomaly !== want.eccentric_anomaly)
                begin
                    $display("%0t: eccentric_anomaly expected %h actual %h", $time,
                             want.eccentric_anomaly, rsp_data.eccentric_anomaly);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        err_cnt = 0;
        hold_off_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        wait_drained();
        send_idle_pct = 10;
        recv_idle_pct = 46;
        test_random(250);
        send_idle_pct = 46;
        recv_idle_pct = 10;
        test_random(250);
        // sender pause until all results are back
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(250);
        test_backpressure();

        wait_drained();
        repeat (30) @(negedge clk);
        if (err_cnt == 0 && anomaly_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

`default_nettype wire

[kepler_eccentric_anomaly_series.f]
+incdir+sv
sv/kepea_pkg.sv
sv/kepea_sin_lane.sv
sv/kepler_eccentric_anomaly_series.sv
sv/kepea_sva.sv
tb/tb.sv
